[rtl/quadratic_equation_solver_assert.svh]
// ----------------------------------------------------------------------------
// Quadratic equation solver assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_EQUATION_SOLVER_ASSERT_SVH
`define QUADRATIC_EQUATION_SOLVER_ASSERT_SVH

// same-cycle implication
`define QES_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("quadratic_equation_solver: assertion failed");

// next-cycle implication
`define QES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("quadratic_equation_solver: assertion failed");

`endif

[rtl/qes_pkg.sv]
// ----------------------------------------------------------------------------
// qes_pkg
// Types and constants of the quadratic equation solver.
// ----------------------------------------------------------------------------
package qes_pkg;

  localparam int COEF_W     = 32;
  localparam int DISC_W     = 64;
  localparam int SQRT_STEPS = 32;
  localparam int REM_W      = 35;
  localparam int SH_W       = 64;
  localparam int DEN_W      = 33;
  localparam int NB_W       = 34;

  localparam logic       OP_ADD   = 1'b0;
  localparam logic       OP_SOLVE = 1'b1;
  localparam logic [1:0] POW_C    = 2'd0;
  localparam logic [1:0] POW_B    = 2'd1;
  localparam logic [1:0] POW_A    = 2'd2;
  localparam logic [1:0] POW_NONE = 2'd3;

  localparam logic [1:0] STAT_NONE = 2'd0;
  localparam logic [1:0] STAT_ONE  = 2'd1;
  localparam logic [1:0] STAT_TWO  = 2'd2;
  localparam logic [1:0] STAT_ALL  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_BB,
    ST_MUL_AC,
    ST_DISC,
    ST_CLASS,
    ST_SQRT,
    ST_LOAD,
    ST_DIV,
    ST_DIV_END,
    ST_DONE
  } qes_state_e;

  typedef enum logic [1:0] {
    DIV_LIN,
    DIV_DBL,
    DIV_ROOT1,
    DIV_ROOT2
  } qes_div_e;

endpackage

[rtl/quadratic_equation_solver.sv]
// ----------------------------------------------------------------------------
// Quadratic equation solver
// Accumulates Q.F coefficients a, b, c and solves a*X^2 + b*X + c = 0.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// s_axis   in   [31:0] coefficient, [33:32] power       opcode
// m_axis   out  [63:0] discriminant, [95:64] root_one,  status
//               [127:96] root_two
//
// An add-term word updates its coefficient when accepted. A solve word runs two
// multiplies, discriminant and classify, a bit-serial square root, then per
// division a load step, compare/subtract steps and a result step, all on one
// shared unit, and returns to idle through ST_DONE before the next word is
// accepted. s_axis_tready is low while a solve runs; a finished word waits in
// the output register. Reset clears a, b, c.
// ----------------------------------------------------------------------------
module quadratic_equation_solver #(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // coefficient, power, zero pad
  input  logic         s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // discriminant, root_one, root_two
  output logic [1:0]   m_axis_tuser   // status
);
  import qes_pkg::*;

  localparam int NUM_W = NB_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  qes_state_e state_q, state_d;
  qes_div_e   sel_q;

  logic signed [COEF_W-1:0] coef_a_q, coef_b_q, coef_c_q;
  logic signed [DISC_W-1:0] prod_q, bb_q, disc_q;
  logic [REM_W-1:0]  rem_q;
  logic [SH_W-1:0]   sh_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  den_q;
  logic              neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [31:0]       root_q;
  logic [1:0]        status_q;
  logic [31:0]       r1_q, r2_q;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [63:0]       out_disc_q;
  logic [31:0]       out_r1_q, out_r2_q;

  logic                     in_fire, done_fire;
  logic signed [COEF_W-1:0] in_coef, add_src, add_res;
  logic signed [COEF_W:0]   add_sum;
  logic [1:0]               in_pow;

  logic signed [COEF_W-1:0] mul_x, mul_y;
  logic signed [DISC_W-1:0] mul_p;

  logic signed [DISC_W:0]   m_full;
  logic [DISC_W-1:0]        disc_sat;

  logic                     sq_mode, take;
  logic [REM_W-1:0]         rem_sh, step_op, rem_next;
  logic [REM_W:0]           diff;
  logic [NUM_W-1:0]         quo_next;
  logic [SH_W-1:0]          sh_next;

  logic signed [NB_W-1:0]   a34, b34, c34, s34, nb, ds;
  logic [NB_W-1:0]          nmag, dmag;

  logic                     q_big, q_over;
  logic [31:0]              div_res;

  // ---- handshake
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    in_fire       = s_axis_tvalid && s_axis_tready;
    done_fire     = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  end

  assign in_coef = signed'(s_axis_tdata[31:0]);
  assign in_pow  = s_axis_tdata[33:32];

  // ---- saturating coefficient add
  always_comb begin
    unique case (in_pow)
      POW_A:   add_src = coef_a_q;
      POW_B:   add_src = coef_b_q;
      default: add_src = coef_c_q;
    endcase
    add_sum = {add_src[COEF_W-1], add_src} + {in_coef[COEF_W-1], in_coef};
    if (add_sum[COEF_W] != add_sum[COEF_W-1]) begin
      add_res = add_sum[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      add_res = add_sum[COEF_W-1:0];
    end
  end

  // ---- shared multiplier
  always_comb begin
    mul_x = (state_q == ST_MUL_BB) ? coef_b_q : coef_a_q;
    mul_y = (state_q == ST_MUL_BB) ? coef_b_q : coef_c_q;
    mul_p = mul_x * mul_y;
  end

  // ---- discriminant: 4*(bb/4 - ac) + bb%4, saturated
  always_comb begin
    m_full = {{3{bb_q[DISC_W-1]}}, bb_q[DISC_W-1:2]} - {prod_q[DISC_W-1], prod_q};
    if (!m_full[DISC_W] && (m_full[DISC_W-1:DISC_W-3] != 3'b000)) begin
      disc_sat = {1'b0, {(DISC_W-1){1'b1}}};
    end else if (m_full[DISC_W] && (m_full[DISC_W-1:DISC_W-3] != 3'b111)) begin
      disc_sat = {1'b1, {(DISC_W-1){1'b0}}};
    end else begin
      disc_sat = {m_full[DISC_W-3:0], bb_q[1:0]};
    end
  end

  // ---- shared compare/subtract step (sqrt: 2 bits, divide: 1 bit)
  always_comb begin
    sq_mode = (state_q == ST_SQRT);
    if (sq_mode) begin
      rem_sh  = {rem_q[REM_W-3:0], sh_q[SH_W-1 -: 2]};
      step_op = {quo_q[REM_W-3:0], 2'b01};
      sh_next = {sh_q[SH_W-3:0], 2'b00};
    end else begin
      rem_sh  = {rem_q[REM_W-2:0], sh_q[SH_W-1]};
      step_op = {{(REM_W-DEN_W){1'b0}}, den_q};
      sh_next = {sh_q[SH_W-2:0], 1'b0};
    end
    diff     = {1'b0, rem_sh} - {1'b0, step_op};
    take     = !diff[REM_W];
    rem_next = take ? diff[REM_W-1:0] : rem_sh;
    quo_next = {quo_q[NUM_W-2:0], take};
  end

  // ---- division operands
  always_comb begin
    a34 = {{(NB_W-COEF_W){coef_a_q[COEF_W-1]}}, coef_a_q};
    b34 = {{(NB_W-COEF_W){coef_b_q[COEF_W-1]}}, coef_b_q};
    c34 = {{(NB_W-COEF_W){coef_c_q[COEF_W-1]}}, coef_c_q};
    s34 = {{(NB_W-32){1'b0}}, root_q};
    unique case (sel_q)
      DIV_LIN: begin
        nb = -c34;
        ds = b34;
      end
      DIV_DBL: begin
        nb = -b34;
        ds = a34 <<< 1;
      end
      DIV_ROOT1: begin
        nb = s34 - b34;
        ds = a34 <<< 1;
      end
      default: begin
        nb = -b34 - s34;
        ds = a34 <<< 1;
      end
    endcase
    nmag = nb[NB_W-1] ? -nb : nb;
    dmag = ds[NB_W-1] ? -ds : ds;
  end

  // ---- quotient sign and saturation
  always_comb begin
    q_big = |quo_q[NUM_W-1:32];
    if (neg_q) begin
      q_over  = q_big || (quo_q[31] && (|quo_q[30:0]));
      div_res = q_over ? 32'h8000_0000 : -quo_q[31:0];
    end else begin
      q_over  = q_big || quo_q[31];
      div_res = q_over ? 32'h7FFF_FFFF : quo_q[31:0];
    end
  end

  // ---- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (s_axis_tuser == OP_SOLVE)) state_d = ST_MUL_BB;
      end
      ST_MUL_BB: state_d = ST_MUL_AC;
      ST_MUL_AC: state_d = ST_DISC;
      ST_DISC:   state_d = ST_CLASS;
      ST_CLASS: begin
        priority if (coef_a_q == '0 && coef_b_q == '0) state_d = ST_DONE;
        else if (coef_a_q == '0) state_d = ST_LOAD;
        else if (disc_q == '0) state_d = ST_LOAD;
        else if (!disc_q[DISC_W-1]) state_d = ST_SQRT;
        else state_d = ST_DONE;
      end
      ST_SQRT: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_LOAD;
      end
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_DIV_END;
      end
      ST_DIV_END: state_d = (sel_q == DIV_ROOT1) ? ST_LOAD : ST_DONE;
      ST_DONE: begin
        if (done_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      coef_a_q    <= '0;
      coef_b_q    <= '0;
      coef_c_q    <= '0;
    end else begin
      state_q <= state_d;
      if (done_fire) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (in_fire && (s_axis_tuser == OP_ADD)) begin
        unique case (in_pow)
          POW_A:   coef_a_q <= add_res;
          POW_B:   coef_b_q <= add_res;
          POW_C:   coef_c_q <= add_res;
          default: ;
        endcase
      end
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MUL_BB: prod_q <= mul_p;
      ST_MUL_AC: begin
        bb_q   <= prod_q;
        prod_q <= mul_p;
      end
      ST_DISC: begin
        disc_q <= disc_sat;
        r1_q   <= '0;
        r2_q   <= '0;
      end
      ST_CLASS: begin
        priority if (coef_a_q == '0 && coef_b_q == '0) begin
          status_q <= (coef_c_q == '0) ? STAT_ALL : STAT_NONE;
        end else if (coef_a_q == '0) begin
          status_q <= STAT_ONE;
          sel_q    <= DIV_LIN;
        end else if (disc_q == '0) begin
          status_q <= STAT_ONE;
          sel_q    <= DIV_DBL;
        end else if (!disc_q[DISC_W-1]) begin
          status_q <= STAT_TWO;
          sel_q    <= DIV_ROOT1;
          sh_q     <= disc_q;
          rem_q    <= '0;
          quo_q    <= '0;
          cnt_q    <= CNT_W'(SQRT_STEPS);
        end else begin
          status_q <= STAT_NONE;
        end
      end
      ST_SQRT, ST_DIV: begin
        rem_q <= rem_next;
        quo_q <= quo_next;
        sh_q  <= sh_next;
        cnt_q <= cnt_q - CNT_W'(1);
        if (sq_mode && cnt_q == CNT_W'(1)) root_q <= quo_next[31:0];
      end
      ST_LOAD: begin
        sh_q  <= {nmag, {(SH_W-NB_W){1'b0}}};
        den_q <= dmag[DEN_W-1:0];
        neg_q <= nb[NB_W-1] ^ ds[NB_W-1];
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= CNT_W'(NUM_W);
      end
      ST_DIV_END: begin
        if (sel_q == DIV_ROOT1) begin
          r1_q  <= div_res;
          sel_q <= DIV_ROOT2;
        end else if (sel_q == DIV_ROOT2) begin
          r2_q <= div_res;
        end else begin
          r1_q <= div_res;
        end
      end
      default: ;
    endcase
    if (done_fire) begin
      out_status_q <= status_q;
      out_disc_q   <= disc_q;
      out_r1_q     <= r1_q;
      out_r2_q     <= r2_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_r2_q, out_r1_q, out_disc_q};

  `include "quadratic_equation_solver_assert.svh"

  `QES_ASSERT_NEXT(a_solve_busy, in_fire && (s_axis_tuser == OP_SOLVE), !s_axis_tready)
  `QES_ASSERT_NEXT(a_add_no_word, in_fire && (s_axis_tuser == OP_ADD) && !m_axis_tvalid, !m_axis_tvalid)
  `QES_ASSERT_IMPL(a_two_pos_disc, m_axis_tvalid && (m_axis_tuser == STAT_TWO), !m_axis_tdata[63] && (m_axis_tdata[63:0] != '0))
  `QES_ASSERT_IMPL(a_all_zero_roots, m_axis_tvalid && (m_axis_tuser == STAT_ALL), m_axis_tdata[127:64] == '0)

endmodule
